// ===== sv/bvir_pkg.sv =====
// ----------------------------------------------------------------------------
// bvir_pkg
// shared types and constants for the bounded word list with insert and remove
// ----------------------------------------------------------------------------
package bvir_pkg;

    localparam int WORD_W    = 64;
    localparam int REQ_W     = 3;
    localparam int POS_W     = 5;
    localparam int COUNT_W   = 5;
    localparam int STATUS_W  = 2;
    localparam int DEPTH_DEF = 16;

    typedef logic [REQ_W-1:0]    req_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam req_t REQ_CLEAR     = 3'd0;
    localparam req_t REQ_PUSH      = 3'd1;
    localparam req_t REQ_POP       = 3'd2;
    localparam req_t REQ_READ_LAST = 3'd3;
    localparam req_t REQ_INSERT    = 3'd4;
    localparam req_t REQ_REMOVE    = 3'd5;
    localparam req_t REQ_DUMP      = 3'd6;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

    localparam logic [WORD_W-1:0] QNAN_WORD = 64'h7FF8_0000_0000_0000;

    typedef struct packed {
        req_t               req_type;
        logic [POS_W-1:0]   position;
        logic [WORD_W-1:0]  item_value;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0]  out_value;
        logic [COUNT_W-1:0] elem_count;
        status_t            status;
        logic               last_of_run;
    } out_word_t;

    typedef struct packed {
        logic exec;
        logic dump_start;
        logic dump_step;
    } bvir_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic dump_last;
    } bvir_status_t;

endpackage

// ===== sv/bounded_vector_insert_remove.sv =====
// ----------------------------------------------------------------------------
// bounded_vector_insert_remove
// ordered list of up to DEPTH 64-bit words with insert, remove and dump
// ----------------------------------------------------------------------------
// The list lives in a row of DEPTH shift cells that move in parallel, so clear,
// push, pop, read last, insert and remove each load the output word register
// when accepted: a new request is accepted every cycle while the output word
// register is free or being taken. A dump of n stored words loads one word per
// cycle through the single cell read port while the output register is free or
// being taken; no request is accepted until its last word is loaded. An empty
// dump gives one word with status empty. Full pushes or inserts are refused
// with status full, and a remove at or past the count reports out of range.
module bounded_vector_insert_remove
#(
    parameter int DEPTH = bvir_pkg::DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  bvir_pkg::in_word_t  in_word,
    output logic                out_valid,
    input  logic                out_ready,
    output bvir_pkg::out_word_t out_word
);
    import bvir_pkg::*;

    bvir_cmd_t    cmd;
    bvir_status_t dp_status;

    bvir_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .req_type  (in_word.req_type),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .dp_status (dp_status)
    );

    bvir_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_word   (in_word),
        .cmd       (cmd),
        .dp_status (dp_status),
        .out_word  (out_word)
    );

endmodule

// ===== sv/bvir_ctrl.sv =====
// ----------------------------------------------------------------------------
// bvir_ctrl
// handshake control and dump sequencing for the word list
// ----------------------------------------------------------------------------
module bvir_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  bvir_pkg::req_t        req_type,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output bvir_pkg::bvir_cmd_t   cmd,
    input  bvir_pkg::bvir_status_t dp_status
);
    import bvir_pkg::*;

    typedef enum logic {
        S_IDLE,
        S_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;
    logic   accept;
    logic   is_dump;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign accept    = in_valid && in_ready;
    assign is_dump   = (req_type == REQ_DUMP);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.exec       = accept && !(is_dump && !dp_status.count_zero);
        cmd.dump_start = accept && is_dump && !dp_status.count_zero;
        cmd.dump_step  = (state_reg == S_DUMP) && out_free;

        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.dump_start)
                    state_next = S_DUMP;
            end
            S_DUMP:
            begin
                if (cmd.dump_step && dp_status.dump_last)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.exec || cmd.dump_step)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef SYNTH
    a_one_source: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.exec && cmd.dump_step))
        else $error("single request and dump step loaded together");

    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec || cmd.dump_step) |=> out_valid_reg)
        else $error("loaded word not presented");

    a_dump_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_start |=> !in_ready)
        else $error("input taken while dump starts");
`endif

endmodule

// ===== sv/bvir_datapath.sv =====
// ----------------------------------------------------------------------------
// bvir_datapath
// shift cells, word count, dump index and the output word register
// ----------------------------------------------------------------------------
module bvir_datapath
#(
    parameter int DEPTH = bvir_pkg::DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  bvir_pkg::in_word_t     in_word,
    input  bvir_pkg::bvir_cmd_t    cmd,
    output bvir_pkg::bvir_status_t dp_status,
    output bvir_pkg::out_word_t    out_word
);
    import bvir_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    logic [WORD_W-1:0] cells_reg  [DEPTH];
    logic [WORD_W-1:0] cells_next [DEPTH];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    out_word_t         out_reg;
    out_word_t         out_next;

    logic [CMP_W-1:0]  pos_x;
    logic [CMP_W-1:0]  cnt_x;
    logic [CMP_W-1:0]  ins_x;
    logic              full;
    logic              empty;
    logic              do_ins;
    logic              do_rem;
    logic [CNT_W-1:0]  last_pos;
    logic [IDX_W-1:0]  rd_addr;
    logic [WORD_W-1:0] rd_data;
    logic              dump_last;

    assign pos_x     = CMP_W'(in_word.position);
    assign cnt_x     = CMP_W'(count_reg);
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign last_pos  = count_reg - CNT_W'(1);
    assign dump_last = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);
    assign rd_addr   = (cmd.dump_step) ? idx_reg : last_pos[IDX_W-1:0];
    assign rd_data   = cells_reg[rd_addr];

    assign dp_status.count_zero = empty;
    assign dp_status.dump_last  = dump_last;
    assign out_word             = out_reg;

    always_comb
    begin
        if (in_word.req_type == REQ_PUSH || pos_x > cnt_x)
            ins_x = cnt_x;
        else
            ins_x = pos_x;

        do_ins = cmd.exec && !full &&
                 (in_word.req_type == REQ_PUSH || in_word.req_type == REQ_INSERT);
        do_rem = cmd.exec && (in_word.req_type == REQ_REMOVE) && (pos_x < cnt_x);

        for (int i = 0; i < DEPTH; i++)
        begin
            cells_next[i] = cells_reg[i];
            if (do_ins)
            begin
                if (CMP_W'(i) > ins_x)
                    cells_next[i] = cells_reg[(i > 0) ? i - 1 : 0];
                else if (CMP_W'(i) == ins_x)
                    cells_next[i] = in_word.item_value;
            end
            else if (do_rem)
            begin
                if (CMP_W'(i) >= pos_x)
                    cells_next[i] = cells_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        out_next   = out_reg;
        idx_next   = idx_reg;

        if (cmd.dump_start)
            idx_next = '0;
        else if (cmd.dump_step)
            idx_next = idx_reg + IDX_W'(1);

        if (cmd.exec)
        begin
            out_next.out_value   = '0;
            out_next.status      = ST_OK;
            out_next.last_of_run = 1'b1;
            unique case (in_word.req_type)
                REQ_CLEAR:
                begin
                    count_next = '0;
                end
                REQ_PUSH, REQ_INSERT:
                begin
                    if (full)
                        out_next.status = ST_FULL;
                    else
                        count_next = count_reg + CNT_W'(1);
                end
                REQ_POP:
                begin
                    if (empty)
                        out_next.status = ST_EMPTY;
                    else
                        count_next = last_pos;
                end
                REQ_READ_LAST:
                begin
                    if (empty)
                    begin
                        out_next.status    = ST_EMPTY;
                        out_next.out_value = QNAN_WORD;
                    end
                    else
                    begin
                        out_next.out_value = rd_data;
                    end
                end
                REQ_REMOVE:
                begin
                    if (do_rem)
                        count_next = last_pos;
                    else
                        out_next.status = ST_RANGE;
                end
                REQ_DUMP:
                begin
                    out_next.status = ST_EMPTY;
                end
                default:
                begin
                    out_next.status = ST_OK;
                end
            endcase
            out_next.elem_count = COUNT_W'(count_next);
        end
        else if (cmd.dump_step)
        begin
            out_next.out_value   = rd_data;
            out_next.elem_count  = COUNT_W'(count_reg);
            out_next.status      = ST_OK;
            out_next.last_of_run = dump_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cells_reg <= cells_next;
        out_reg   <= out_next;
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("word count past depth");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.exec && !full && in_word.req_type == REQ_PUSH)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not grow the list");

    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.dump_step |-> !empty && $stable(count_reg))
        else $error("dump step on empty or changing list");
`endif

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the bounded word list with insert, remove and dump
// ----------------------------------------------------------------------------
// A short table of directed requests covers the empty edge, the clamped
// insert, the out of range remove and both kinds of dump. Random episodes
// then fill, shuffle and drain the list. Every word taken from the block is
// compared field by field with the row's expected word, if given, or else with
// a list model kept in the bench. The sender works in bursts with gaps; the
// receiver stalls in patterns of its own and once holds off long enough to
// back the block up. The sender at times waits for every expected word.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bvir_pkg::*;

    localparam int LIST_DEPTH      = DEPTH_DEF;
    localparam int RANDOM_ITEMS    = 100;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int DRAIN_CYCLES    = 40;
    localparam int MAX_REPORTS     = 40;
    localparam int DIR_ROWS        = 22;

    localparam logic [WORD_W-1:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [WORD_W-1:0] NEG_ZERO = 64'h8000_0000_0000_0000;
    localparam logic [WORD_W-1:0] POS_INF  = 64'h7FF0_0000_0000_0000;
    localparam logic [WORD_W-1:0] MIN_SUB  = 64'h0000_0000_0000_0001;
    localparam logic [WORD_W-1:0] ALT_5    = 64'h5555_5555_5555_5555;
    localparam logic [WORD_W-1:0] ALT_A    = 64'hAAAA_AAAA_AAAA_AAAA;

    typedef struct packed {
        in_word_t  req;
        logic      typed;
        out_word_t want;
    } dir_row_t;

    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{'{REQ_READ_LAST, 5'd0,  64'd0},    1'b1, '{QNAN_WORD, 5'd0, ST_EMPTY, 1'b1}},
        '{'{REQ_POP,       5'd16, ALL_ONES}, 1'b1, '{64'd0,     5'd0, ST_EMPTY, 1'b1}},
        '{'{REQ_DUMP,      5'd0,  64'd0},    1'b1, '{64'd0,     5'd0, ST_EMPTY, 1'b1}},
        '{'{REQ_REMOVE,    5'd0,  ALL_ONES}, 1'b1, '{64'd0,     5'd0, ST_RANGE, 1'b1}},
        '{'{REQ_PUSH,      5'd0,  64'd0},    1'b1, '{64'd0,     5'd1, ST_OK,    1'b1}},
        '{'{REQ_PUSH,      5'd16, ALL_ONES}, 1'b1, '{64'd0,     5'd2, ST_OK,    1'b1}},
        '{'{REQ_READ_LAST, 5'd16, 64'd0},    1'b1, '{ALL_ONES,  5'd2, ST_OK,    1'b1}},
        '{'{REQ_INSERT,    5'd0,  NEG_ZERO}, 1'b1, '{64'd0,     5'd3, ST_OK,    1'b1}},
        '{'{REQ_INSERT,    5'd16, POS_INF},  1'b1, '{64'd0,     5'd4, ST_OK,    1'b1}},
        '{'{REQ_INSERT,    5'd2,  MIN_SUB},  1'b0, '0},
        '{'{REQ_READ_LAST, 5'd0,  ALT_5},    1'b0, '0},
        '{'{REQ_DUMP,      5'd16, ALT_A},    1'b0, '0},
        '{'{REQ_REMOVE,    5'd4,  64'd0},    1'b0, '0},
        '{'{REQ_REMOVE,    5'd0,  64'd0},    1'b0, '0},
        '{'{REQ_REMOVE,    5'd16, ALT_A},    1'b1, '{64'd0,     5'd3, ST_RANGE, 1'b1}},
        '{'{REQ_REMOVE,    5'd3,  64'd0},    1'b1, '{64'd0,     5'd3, ST_RANGE, 1'b1}},
        '{'{REQ_INSERT,    5'd15, ALT_5},    1'b0, '0},
        '{'{REQ_DUMP,      5'd0,  64'd0},    1'b0, '0},
        '{'{REQ_CLEAR,     5'd16, ALL_ONES}, 1'b1, '{64'd0,     5'd0, ST_OK,    1'b1}},
        '{'{REQ_READ_LAST, 5'd0,  64'd0},    1'b1, '{QNAN_WORD, 5'd0, ST_EMPTY, 1'b1}},
        '{'{REQ_PUSH,      5'd0,  ALT_A},    1'b1, '{64'd0,     5'd1, ST_OK,    1'b1}},
        '{'{REQ_POP,       5'd0,  64'd0},    1'b1, '{64'd0,     5'd0, ST_OK,    1'b1}}
    };

    logic      clk;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    in_word_t  in_word   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_word_t out_word;

    logic [WORD_W-1:0] list_mem [LIST_DEPTH];
    int                list_len;
    out_word_t         pending_words [$];

    int n_sent;
    int n_checked;
    int n_dump_words;
    int err_count;
    int status_hits [4];
    int burst_left;
    bit hold_off_go = 1'b0;

    bounded_vector_insert_remove #(
        .DEPTH (LIST_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL bounded_vector_insert_remove");
        $finish;
    end

    // list model: works out the words one request gives
    task automatic predict_request(input in_word_t req, input logic typed,
                                   input out_word_t want);
        out_word_t res;
        int        slot;
        res             = '0;
        res.status      = ST_OK;
        res.last_of_run = 1'b1;
        slot            = int'(req.position);
        case (req.req_type)
            REQ_CLEAR:
                list_len = 0;
            REQ_PUSH, REQ_INSERT:
                if (list_len >= LIST_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    if (req.req_type == REQ_PUSH || slot > list_len)
                        slot = list_len;
                    for (int i = list_len; i > slot; i--)
                        list_mem[i] = list_mem[i-1];
                    list_mem[slot] = req.item_value;
                    list_len++;
                end
            REQ_POP:
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else
                    list_len--;
            REQ_READ_LAST:
                if (list_len == 0)
                begin
                    res.status    = ST_EMPTY;
                    res.out_value = QNAN_WORD;
                end
                else
                    res.out_value = list_mem[list_len-1];
            REQ_REMOVE:
                if (slot >= list_len)
                    res.status = ST_RANGE;
                else
                begin
                    for (int i = slot; i + 1 < list_len; i++)
                        list_mem[i] = list_mem[i+1];
                    list_len--;
                end
            REQ_DUMP:
                if (list_len == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    for (int i = 0; i < list_len; i++)
                    begin
                        res.out_value   = list_mem[i];
                        res.elem_count  = list_len[COUNT_W-1:0];
                        res.last_of_run = (i == list_len - 1);
                        pending_words.push_back(res);
                    end
                    n_dump_words += list_len;
                end
            default:
                ;
        endcase
        status_hits[res.status]++;
        if (!(req.req_type == REQ_DUMP && list_len != 0))
        begin
            res.elem_count = list_len[COUNT_W-1:0];
            pending_words.push_back(typed ? want : res);
        end
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return QNAN_WORD;
            3:       return NEG_ZERO;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic in_word_t make_req(input req_t op, input int pos);
        in_word_t w;
        w.req_type   = op;
        w.position   = pos[POS_W-1:0];
        w.item_value = rand_word();
        return w;
    endfunction

    function automatic void note_mismatch(input string field,
                                          input logic [WORD_W-1:0] want_v,
                                          input logic [WORD_W-1:0] got_v);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h got %h", $time, field, want_v, got_v);
    endfunction

    // sender: bursts of random length with random gaps
    task automatic offer(input in_word_t w, input logic typed = 1'b0,
                         input out_word_t want = '0);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        n_sent++;
        predict_request(w, typed, want);
    endtask

    task automatic wait_all_taken();
        in_valid   <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (pending_words.size() != 0);
    endtask

    task automatic fill_list();
        while (list_len < LIST_DEPTH)
            offer(make_req($urandom_range(0, 1) ? REQ_PUSH : REQ_INSERT,
                           $urandom_range(0, LIST_DEPTH)));
        offer(make_req(REQ_PUSH, $urandom_range(0, LIST_DEPTH)));
        offer(make_req(REQ_INSERT, $urandom_range(0, LIST_DEPTH)));
        offer(make_req(REQ_DUMP, $urandom_range(0, LIST_DEPTH)));
    endtask

    task automatic mix_list(input int n);
        int   pick;
        int   pos;
        req_t op;
        repeat (n)
        begin
            pick = $urandom_range(0, 99);
            pos  = $urandom_range(0, LIST_DEPTH);
            if (pick < 25)
                op = REQ_PUSH;
            else if (pick < 45)
                op = REQ_INSERT;
            else if (pick < 55)
                op = REQ_POP;
            else if (pick < 65)
                op = REQ_READ_LAST;
            else if (pick < 85)
            begin
                op = REQ_REMOVE;
                if (list_len > 0 && $urandom_range(0, 3) != 0)
                    pos = $urandom_range(0, list_len - 1);
            end
            else if (pick < 96)
                op = REQ_DUMP;
            else
                op = REQ_CLEAR;
            offer(make_req(op, pos));
        end
    endtask

    task automatic drain_list();
        while (list_len > 0)
            offer(make_req($urandom_range(0, 2) == 0 ? REQ_POP : REQ_REMOVE,
                           $urandom_range(0, list_len - 1)));
        offer(make_req(REQ_POP, $urandom_range(0, LIST_DEPTH)));
        offer(make_req(REQ_READ_LAST, $urandom_range(0, LIST_DEPTH)));
        offer(make_req(REQ_REMOVE, $urandom_range(0, LIST_DEPTH)));
        offer(make_req(REQ_DUMP, $urandom_range(0, LIST_DEPTH)));
    endtask

    // receiver: stretches of random stall density, plus one long hold-off
    initial
    begin
        int stretch;
        int stall_pct;
        forever
        begin
            if (hold_off_go)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_go = 1'b0;
            end
            else
            begin
                stretch = $urandom_range(4, 40);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 25;
                    2:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
                for (int k = 0; k < stretch && !hold_off_go; k++)
                begin
                    out_ready <= ($urandom_range(0, 99) >= stall_pct);
                    @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                err_count++;
                $display("%0t: word %h taken with nothing expected", $time, out_word);
            end
            else
            begin
                want = pending_words.pop_front();
                n_checked++;
                if (out_word.out_value !== want.out_value)
                    note_mismatch("out_value", want.out_value, out_word.out_value);
                if (out_word.elem_count !== want.elem_count)
                    note_mismatch("elem_count", WORD_W'(want.elem_count),
                                  WORD_W'(out_word.elem_count));
                if (out_word.status !== want.status)
                    note_mismatch("status", WORD_W'(want.status),
                                  WORD_W'(out_word.status));
                if (out_word.last_of_run !== want.last_of_run)
                    note_mismatch("last_of_run", WORD_W'(want.last_of_run),
                                  WORD_W'(out_word.last_of_run));
            end
        end
    end

    initial
    begin
        int episode;
        int pick;
        do @(posedge clk); while (!rst_n);
        for (int k = 0; k < DIR_ROWS; k++)
            offer(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);
        episode = 0;
        while (n_sent < DIR_ROWS + RANDOM_ITEMS)
        begin
            case (episode)
                0:
                    fill_list();
                1:
                    mix_list($urandom_range(10, 20));
                2:
                begin
                    // back the block up while words keep coming
                    hold_off_go = 1'b1;
                    burst_left  = 40;
                    mix_list(24);
                end
                3:
                begin
                    wait_all_taken();
                    drain_list();
                end
                default:
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 3)
                        fill_list();
                    else if (pick < 8)
                        mix_list($urandom_range(6, 20));
                    else
                        drain_list();
                end
            endcase
            episode++;
        end
        wait_all_taken();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("ran %0d requests over %0d episodes, checked %0d words (%0d from dumps)",
                 n_sent, episode, n_checked, n_dump_words);
        $display("refused or flagged: %0d full, %0d empty, %0d out of range",
                 status_hits[ST_FULL], status_hits[ST_EMPTY], status_hits[ST_RANGE]);
        if (err_count == 0)
            $display("PASS bounded_vector_insert_remove");
        else
            $display("FAIL bounded_vector_insert_remove");
        $finish;
    end

endmodule
